FILE: rtl/pdu_pkg.sv
// Package for the pair distance / unit vector pipeline.
// Widths, pipeline depths and stage record types; no dependencies.
package pdu_pkg;

	localparam int TagW    = 12;
	localparam int CoordW  = 24;
	localparam int DiffW   = CoordW + 1;        // signed difference, Q9.16
	localparam int SqW     = 2 * DiffW;         // one square
	localparam int SumW    = SqW;               // sum of three squares stays below 2^50
	localparam int RemW    = SumW + 2;          // sqrt remainder with headroom
	localparam int DistW   = 25;
	localparam int GradW   = 18;
	localparam int FracW   = 16;
	localparam int QuoW    = FracW + 1;         // quotient never above 2^16
	localparam int NumW    = DiffW + FracW + 1; // dividend with rounding half
	localparam int SqSteps = DistW;             // one root bit per stage
	localparam int DvSteps = QuoW;              // one quotient bit per stage
	localparam int InW     = 2 * TagW + 6 * CoordW;
	localparam int OutW    = 104;
	localparam logic [QuoW-1:0] GradOne = QuoW'(1) << FracW;

	typedef struct packed {
		logic [TagW-1:0]              row;
		logic [TagW-1:0]              col;
		logic [2:0]                   neg;
		logic [2:0][DiffW-1:0]        mag;
		logic                         zero;
		logic [RemW-1:0]              rem;
		logic [DistW-1:0]             root;
	} sq_rec_t;

	typedef struct packed {
		logic [TagW-1:0]              row;
		logic [TagW-1:0]              col;
		logic [2:0]                   neg;
		logic                         zero;
		logic [DistW-1:0]             d;
		logic [2:0][NumW-1:0]         rem;
		logic [2:0][QuoW-1:0]         quo;
	} dv_rec_t;

endpackage

FILE: rtl/pair_distance_unit_vector_top.sv
// Top level: distance and unit vector of one atom / grid point pair per request.
// Uses pdu_pkg; checker pdu_chk binds to it.
//
//  channel | signals                        | direction | contents
//  s_*     | s_tvalid s_tready s_tdata[167:0] | in      | one pair request
//  m_*     | m_tvalid m_tready m_tdata[103:0] m_tuser | out | one result
//
// Takes one request per cycle while the output is not stalled; stages: 3 setup
// stages, sum, 25 root stages, rounding, 17 divider stages, output register.
// The root and the divider retire one bit per stage, which sets the depth.
// arst_n clears all valid bits only; the block keeps no other state.
// A stall of m_tready freezes every stage together; s_tready drops with it.
module pair_distance_unit_vector_top
	import pdu_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	// grid_index, atom_index, atom_x, atom_y, atom_z, point_x, point_y, point_z
	input  logic [InW-1:0]  s_tdata,
	output logic            m_tvalid,
	input  logic            m_tready,
	// row_tag, column_tag, distance, grad_x, grad_y, grad_z, zero pad
	output logic [OutW-1:0] m_tdata,
	// coincident
	output logic            m_tuser
);

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// stage 1: differences
	logic                    v_s1;
	logic [TagW-1:0]         row_s1, col_s1;
	logic [2:0][DiffW-1:0]   dif_s1;
	// stage 2: magnitudes
	logic                    v_s2;
	logic [TagW-1:0]         row_s2, col_s2;
	logic [2:0]              neg_s2;
	logic [2:0][DiffW-1:0]   mag_s2;
	// stage 3: squares
	logic                    v_s3;
	logic [TagW-1:0]         row_s3, col_s3;
	logic [2:0]              neg_s3;
	logic [2:0][DiffW-1:0]   mag_s3;
	logic [2:0][SqW-1:0]     sqr_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_s1 <= s_tdata[TagW-1:0];
			col_s1 <= s_tdata[2*TagW-1:TagW];
			for (int j = 0; j < 3; j++) begin
				dif_s1[j] <= DiffW'($signed(s_tdata[2*TagW+j*CoordW +: CoordW]))
					- DiffW'($signed(s_tdata[2*TagW+(j+3)*CoordW +: CoordW]));
			end
			row_s2 <= row_s1;
			col_s2 <= col_s1;
			for (int j = 0; j < 3; j++) begin
				neg_s2[j] <= dif_s1[j][DiffW-1];
				mag_s2[j] <= dif_s1[j][DiffW-1] ? (~dif_s1[j] + DiffW'(1)) : dif_s1[j];
			end
			row_s3 <= row_s2;
			col_s3 <= col_s2;
			neg_s3 <= neg_s2;
			mag_s3 <= mag_s2;
			for (int j = 0; j < 3; j++) begin
				sqr_s3[j] <= mag_s2[j] * mag_s2[j];
			end
		end
	end

	// square root: sq_s[0] holds the sum, each later stage settles one root bit
	logic    sq_v_s [SqSteps+1];
	sq_rec_t sq_s   [SqSteps+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s[0] <= 1'b0;
		end else if (en) begin
			sq_v_s[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s[0].row  <= row_s3;
			sq_s[0].col  <= col_s3;
			sq_s[0].neg  <= neg_s3;
			sq_s[0].mag  <= mag_s3;
			sq_s[0].zero <= (sqr_s3[0] | sqr_s3[1] | sqr_s3[2]) == '0;
			sq_s[0].rem  <= RemW'(sqr_s3[0]) + RemW'(sqr_s3[1]) + RemW'(sqr_s3[2]);
			sq_s[0].root <= '0;
		end
	end

	for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
		localparam int I = SqSteps - 1 - k;
		logic [RemW-1:0] trial;
		logic            take;
		sq_rec_t         nxt;
		// (root + 2^I)^2 - root^2, root has no bits below I+1
		assign trial = (RemW'(sq_s[k].root) << (I + 1)) | (RemW'(1) << (2 * I));
		assign take  = sq_s[k].rem >= trial;

		always_comb begin
			nxt = sq_s[k];
			if (take) begin
				nxt.rem  = sq_s[k].rem - trial;
				nxt.root = sq_s[k].root | (DistW'(1) << I);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (en) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[k+1] <= nxt;
			end
		end
	end

	// rounding to nearest, then dividend setup; dv_s[0] holds it
	logic    dv_v_s [DvSteps+1];
	dv_rec_t dv_s   [DvSteps+1];
	logic [DistW-1:0] d_rnd;
	assign d_rnd = sq_s[SqSteps].root
		+ DistW'(sq_s[SqSteps].rem > RemW'(sq_s[SqSteps].root));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			dv_v_s[0] <= sq_v_s[SqSteps];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0].row  <= sq_s[SqSteps].row;
			dv_s[0].col  <= sq_s[SqSteps].col;
			dv_s[0].neg  <= sq_s[SqSteps].neg;
			dv_s[0].zero <= sq_s[SqSteps].zero;
			dv_s[0].d    <= d_rnd;
			for (int j = 0; j < 3; j++) begin
				dv_s[0].rem[j] <= (NumW'(sq_s[SqSteps].mag[j]) << FracW)
					+ NumW'(d_rnd[DistW-1:1]);
			end
			dv_s[0].quo <= '0;
		end
	end

	for (genvar k = 0; k < DvSteps; k++) begin : g_div
		localparam int I = DvSteps - 1 - k;
		logic [NumW-1:0] dsh;
		dv_rec_t         nxt;
		assign dsh = NumW'(dv_s[k].d) << I;

		always_comb begin
			nxt = dv_s[k];
			for (int j = 0; j < 3; j++) begin
				if (dv_s[k].rem[j] >= dsh) begin
					nxt.rem[j] = dv_s[k].rem[j] - dsh;
					nxt.quo[j] = dv_s[k].quo[j] | (QuoW'(1) << I);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[k+1] <= dv_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[k+1] <= nxt;
			end
		end
	end

	// output register
	dv_rec_t          fin;
	logic [2:0][GradW-1:0] grad;
	always_comb begin
		fin = dv_s[DvSteps];
		for (int j = 0; j < 3; j++) begin
			logic [QuoW-1:0] q;
			q       = (fin.quo[j] > GradOne) ? GradOne : fin.quo[j];
			grad[j] = fin.neg[j] ? (~GradW'(q) + GradW'(1)) : GradW'(q);
			if (fin.zero) begin
				grad[j] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= dv_v_s[DvSteps];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {1'b0, grad[2], grad[1], grad[0],
				fin.zero ? DistW'(1) : fin.d, fin.col, fin.row};
			m_tuser <= fin.zero;
		end
	end

endmodule

FILE: rtl/pdu_chk.sv
// Port-level checker for pair_distance_unit_vector_top, attached by bind.
// Uses pdu_pkg for field widths.
module pdu_chk
	import pdu_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	input logic            s_tvalid,
	input logic            s_tready,
	input logic [InW-1:0]  s_tdata,
	input logic            m_tvalid,
	input logic            m_tready,
	input logic [OutW-1:0] m_tdata,
	input logic            m_tuser
);

	// a result waiting for the sink holds still
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// an empty output stage never blocks new requests
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("request refused with empty output");

	// clamped result: distance one LSB and zero gradients
	a_coin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[48:24] == 25'd1 && m_tdata[102:49] == '0)
		else $error("coincident result malformed");

	// distance never zero
	a_dist: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[48:24] != '0)
		else $error("zero distance delivered");

endmodule

bind pair_distance_unit_vector_top pdu_chk u_pdu_chk (.*);
